[hw/rtl/brf_pkg.sv]
// ----------------------------------------------------------------------------
// brf_pkg: shared types and constants of the byte ring FIFO
// Request codes, beat structs and the status passed from control to top.
// ----------------------------------------------------------------------------
package brf_pkg;

    // default ring depth in bytes
    localparam int DEPTH_DEFAULT = 256;

    // width of the byte count field on the result beat
    localparam int COUNT_W = 9;

    // terminator that raises a parse request
    localparam logic [7:0] TERMINATOR = 8'h3B;

    // request codes
    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_PEEK  = 2'd2;

    // request beat
    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] data_byte;
        logic [7:0] peek_offset;
    } req_beat_t;

    // result beat
    typedef struct packed {
        logic [7:0]         read_data;
        logic               error_flag;
        logic [COUNT_W-1:0] byte_count;
        logic               parse_request;
    } rsp_beat_t;

    // result status decided at accept time, completed after the memory read
    typedef struct packed {
        logic               use_mem;
        logic               error_flag;
        logic [COUNT_W-1:0] byte_count;
        logic               parse_request;
    } res_info_t;

endpackage

[hw/rtl/brf_ram.sv]
// ----------------------------------------------------------------------------
// brf_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // storage and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/brf_ctrl.sv]
// ----------------------------------------------------------------------------
// brf_ctrl: ring pointers and fill state
// Decides each request, drives the RAM port and the result status.
// ----------------------------------------------------------------------------
module brf_ctrl #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     take,
    input  brf_pkg::req_beat_t       req,
    output logic                     mem_we,
    output logic                     mem_re,
    output logic [$clog2(DEPTH)-1:0] mem_addr,
    output logic [7:0]               mem_wdata,
    output brf_pkg::res_info_t       info
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = ((PTR_W > 8) ? PTR_W : 8) + 1;
    localparam int OFS_W = (CNT_W > 8) ? CNT_W : 8;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

    typedef enum logic [1:0] {
        FILL_EMPTY,
        FILL_DATA,
        FILL_FULL
    } fill_t;

    fill_t            fill_reg, fill_next;
    logic [PTR_W-1:0] wp_reg, wp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;

    logic [CNT_W-1:0] cur_cnt;
    logic [CNT_W-1:0] cnt_after;
    logic [PTR_W-1:0] wp_inc;
    logic [PTR_W-1:0] rp_inc;
    logic [SUM_W-1:0] peek_sum;
    logic [PTR_W-1:0] peek_addr;
    logic             is_write;
    logic             is_read;
    logic             is_peek;
    logic             wr_ok;
    logic             rd_ok;
    logic             pk_ok;

    // current count and pointer increments
    always_comb
    begin
        if (fill_reg == FILL_FULL)
        begin
            cur_cnt = CNT_W'(DEPTH);
        end
        else if (wp_reg >= rp_reg)
        begin
            cur_cnt = CNT_W'(wp_reg - rp_reg);
        end
        else
        begin
            cur_cnt = CNT_W'(DEPTH) - CNT_W'(rp_reg) + CNT_W'(wp_reg);
        end
        wp_inc = (wp_reg == PTR_LAST) ? '0 : wp_reg + 1'b1;
        rp_inc = (rp_reg == PTR_LAST) ? '0 : rp_reg + 1'b1;
    end

    // peek address wraps once at most, offset stays below the count
    always_comb
    begin
        peek_sum = SUM_W'(rp_reg) + SUM_W'(req.peek_offset);
        if (peek_sum >= SUM_W'(DEPTH))
        begin
            peek_sum = peek_sum - SUM_W'(DEPTH);
        end
        peek_addr = peek_sum[PTR_W-1:0];
    end

    // request decode
    always_comb
    begin
        is_write = (req.req_type == brf_pkg::REQ_WRITE);
        is_read  = (req.req_type == brf_pkg::REQ_READ);
        is_peek  = (req.req_type == brf_pkg::REQ_PEEK);
        wr_ok    = is_write && (fill_reg != FILL_FULL);
        rd_ok    = is_read && (fill_reg != FILL_EMPTY);
        pk_ok    = is_peek && (OFS_W'(req.peek_offset) < OFS_W'(cur_cnt));
    end

    // pointer and fill updates
    always_comb
    begin
        wp_next   = wp_reg;
        rp_next   = rp_reg;
        fill_next = fill_reg;
        cnt_after = cur_cnt;
        if (take && wr_ok)
        begin
            wp_next   = wp_inc;
            cnt_after = cur_cnt + 1'b1;
            if (fill_reg == FILL_EMPTY)
            begin
                fill_next = FILL_DATA;
            end
            else if (wp_inc == rp_reg)
            begin
                fill_next = FILL_FULL;
            end
        end
        else if (take && rd_ok)
        begin
            rp_next   = rp_inc;
            cnt_after = cur_cnt - 1'b1;
            if (fill_reg == FILL_FULL)
            begin
                fill_next = FILL_DATA;
            end
            else if (rp_inc == wp_reg)
            begin
                fill_next = FILL_EMPTY;
            end
        end
    end

    // RAM port
    always_comb
    begin
        mem_we    = take && wr_ok;
        mem_re    = take && (rd_ok || pk_ok);
        mem_wdata = req.data_byte;
        case (req.req_type)
            brf_pkg::REQ_READ: mem_addr = rp_reg;
            brf_pkg::REQ_PEEK: mem_addr = peek_addr;
            default:           mem_addr = wp_reg;
        endcase
    end

    // result status
    always_comb
    begin
        info.use_mem       = rd_ok || pk_ok;
        info.error_flag    = (is_write && !wr_ok) || (is_read && !rd_ok)
                             || (is_peek && !pk_ok);
        info.byte_count    = brf_pkg::COUNT_W'(cnt_after);
        info.parse_request = is_write && (req.data_byte == brf_pkg::TERMINATOR);
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= FILL_EMPTY;
            wp_reg   <= '0;
            rp_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            wp_reg   <= wp_next;
            rp_reg   <= rp_next;
        end
    end

`ifndef SYNTHESIS
    // pointers meet only when the ring is empty or full
    a_meet: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_DATA) |-> (wp_reg != rp_reg))
        else $error("brf_ctrl: pointers equal while holding data");

    a_full: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_FULL || fill_reg == FILL_EMPTY) |-> (wp_reg == rp_reg))
        else $error("brf_ctrl: pointers apart while empty or full");

    // a write into a full ring must leave memory untouched
    a_nowr: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == FILL_FULL) |-> !mem_we)
        else $error("brf_ctrl: write issued while full");
`endif

endmodule

[hw/rtl/byte_ring_fifo_with_terminator_unit.sv]
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_terminator_unit: byte receive ring buffer
// Write, read and peek requests on a ring of DEPTH bytes with a parse flag.
// ----------------------------------------------------------------------------
// Usage
//   Request channel req_valid / req_stall / req carries one request per beat:
//   write a byte, read (pop) the oldest byte, or peek at an offset from it.
//   Result channel rsp_valid / rsp_stall / rsp gives exactly one beat per
//   request: the byte read or peeked (zero otherwise), an error flag, the
//   byte count after the request and a parse flag for a ';' on a write request.
//   The result beat passes the synchronous RAM read, which registers the
//   byte while info_reg holds the status, and then the result register.
//   No new request is taken while a result is pending: req_stall is
//   high in the cycle after every accepted request while its result is
//   pending. A result that is not stalled drains in the same cycle as the
//   next request is taken; a stalled result holds req_stall high.
//   Reset clears the pointers and the fill state, so the ring starts empty;
//   memory contents are not cleared and no clearing pass is needed.
//   While rsp_stall is high the result beat holds and requests stall until
//   it is accepted.
// ----------------------------------------------------------------------------
module byte_ring_fifo_with_terminator_unit #(
    parameter int DEPTH = brf_pkg::DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    input  brf_pkg::req_beat_t req,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output brf_pkg::rsp_beat_t rsp
);

    localparam int PTR_W = $clog2(DEPTH);

    logic               take;
    logic               mem_we;
    logic               mem_re;
    logic [PTR_W-1:0]   mem_addr;
    logic [7:0]         mem_wdata;
    logic [7:0]         mem_rdata;
    brf_pkg::res_info_t info;

    logic               pend_reg;
    brf_pkg::res_info_t info_reg;
    logic               rsp_valid_reg, rsp_valid_next;
    brf_pkg::rsp_beat_t rsp_reg, rsp_next;

    // request handshake
    assign req_stall = pend_reg || (rsp_valid_reg && rsp_stall);
    assign take      = req_valid && !req_stall;

    brf_ctrl #(
        .DEPTH(DEPTH)
    ) u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .req      (req),
        .mem_we   (mem_we),
        .mem_re   (mem_re),
        .mem_addr (mem_addr),
        .mem_wdata(mem_wdata),
        .info     (info)
    );

    brf_ram #(
        .WIDTH(8),
        .DEPTH(DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (mem_we),
        .re   (mem_re),
        .addr (mem_addr),
        .wdata(mem_wdata),
        .rdata(mem_rdata)
    );

    // result beat assembly
    always_comb
    begin
        rsp_next.read_data     = info_reg.use_mem ? mem_rdata : 8'd0;
        rsp_next.error_flag    = info_reg.error_flag;
        rsp_next.byte_count    = info_reg.byte_count;
        rsp_next.parse_request = info_reg.parse_request;
        if (pend_reg)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg      <= take;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            info_reg <= info;
        end
        if (pend_reg)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef SYNTHESIS
    // a pending request always lands in the result register next cycle
    a_land: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |=> rsp_valid_reg)
        else $error("brf top: pending result lost");

    // a pending result never finds a stalled, occupied result register
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> !(rsp_valid_reg && rsp_stall))
        else $error("brf top: result register overrun");

    // a stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid_reg && rsp_stall) |=> (rsp_valid_reg && $stable(rsp_reg)))
        else $error("brf top: stalled result changed");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: byte ring FIFO with terminator flag
// Drives write, read, peek and unused requests through the request channel,
// predicts every result beat from a local copy of the ring and checks the
// result channel field by field, with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_HALF    = 5;
    localparam int RING_DEPTH  = brf_pkg::DEPTH_DEFAULT;
    localparam int PTR_W       = $clog2(RING_DEPTH);
    localparam int CNT_W       = brf_pkg::COUNT_W;
    localparam int TOTAL_ITEMS = 1750;

    // request code the block leaves alone
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    typedef enum logic [1:0] {RING_EMPTY, RING_DATA, RING_FULL} ring_fill_t;
    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_BALANCED, MIX_PEEK} traffic_mix_t;

    // a queued request beat, or a marker that holds the sender until idle
    typedef struct {
        bit                 hold_idle;
        brf_pkg::req_beat_t beat;
    } stim_item_t;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_stall;
    brf_pkg::req_beat_t req       = '0;
    logic               rsp_valid;
    logic               rsp_stall = 1'b0;
    brf_pkg::rsp_beat_t rsp;

    stim_item_t         request_queue[$];
    brf_pkg::rsp_beat_t pending_results[$];
    int                 fail_count = 0;

    // local copy of the ring
    logic [7:0]       ring_mem [0:RING_DEPTH-1];
    logic [PTR_W-1:0] wr_ptr;
    logic [PTR_W-1:0] rd_ptr;
    ring_fill_t       ring_fill;

    // sender and receiver pacing
    int tx_idle_left = 0;
    int tx_quiet     = 0;
    int rx_stall_left = 0;
    int rx_quiet     = 0;

    byte_ring_fifo_with_terminator_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always #CLK_HALF clk = ~clk;

    // bytes held in the local ring
    function automatic logic [CNT_W-1:0] ring_count();
        if (ring_fill == RING_FULL)
            return CNT_W'(RING_DEPTH);
        return CNT_W'(PTR_W'(wr_ptr - rd_ptr));
    endfunction

    // apply one request to the local ring and return its result beat
    function automatic brf_pkg::rsp_beat_t ring_predict(input brf_pkg::req_beat_t r);
        brf_pkg::rsp_beat_t res;
        logic [PTR_W-1:0]   peek_ptr;
        res = '0;
        case (r.req_type)
            brf_pkg::REQ_WRITE:
            begin
                res.parse_request = (r.data_byte == brf_pkg::TERMINATOR);
                if (ring_fill == RING_FULL)
                    res.error_flag = 1'b1;
                else
                begin
                    ring_mem[wr_ptr] = r.data_byte;
                    wr_ptr = wr_ptr + 1'b1;
                    if (ring_fill == RING_EMPTY)
                        ring_fill = RING_DATA;
                    else if (wr_ptr == rd_ptr)
                        ring_fill = RING_FULL;
                end
            end
            brf_pkg::REQ_READ:
            begin
                if (ring_fill == RING_EMPTY)
                    res.error_flag = 1'b1;
                else
                begin
                    res.read_data = ring_mem[rd_ptr];
                    rd_ptr = rd_ptr + 1'b1;
                    if (ring_fill == RING_FULL)
                        ring_fill = RING_DATA;
                    else if (wr_ptr == rd_ptr)
                        ring_fill = RING_EMPTY;
                end
            end
            brf_pkg::REQ_PEEK:
            begin
                if (CNT_W'(r.peek_offset) >= ring_count())
                    res.error_flag = 1'b1;
                else
                begin
                    peek_ptr = rd_ptr + PTR_W'(r.peek_offset);
                    res.read_data = ring_mem[peek_ptr];
                end
            end
            default: ;
        endcase
        res.byte_count = ring_count();
        return res;
    endfunction

    // gap length: mostly none or short, a few long, with quiet stretches
    function automatic int pick_gap(inout int quiet);
        int r;
        if (quiet > 0)
        begin
            quiet = quiet - 1;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            quiet = $urandom_range(30, 120);
            return 0;
        end
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic queue_req(input logic [1:0] kind, input logic [7:0] data,
                             input logic [7:0] offset);
        stim_item_t it;
        it.hold_idle        = 1'b0;
        it.beat.req_type    = kind;
        it.beat.data_byte   = data;
        it.beat.peek_offset = offset;
        request_queue.push_back(it);
    endtask

    task automatic queue_hold_idle();
        stim_item_t it;
        it.hold_idle = 1'b1;
        it.beat      = '0;
        request_queue.push_back(it);
    endtask

    function automatic logic [7:0] rand_data();
        if ($urandom_range(0, 7) == 0)
            return brf_pkg::TERMINATOR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] rand_offset();
        if ($urandom_range(0, 1) == 0)
            return 8'($urandom_range(0, 15));
        return 8'($urandom_range(0, 255));
    endfunction

    // request driver: predicts each accepted beat, then presents the next
    always @(posedge clk or negedge rst_n)
    begin
        stim_item_t nxt;
        int         gap_now;
        if (!rst_n)
        begin
            req_valid    <= 1'b0;
            req          <= '0;
            tx_idle_left <= 0;
        end
        else
        begin
            if (req_valid && !req_stall)
                pending_results.push_back(ring_predict(req));
            if (!(req_valid && req_stall))
            begin
                gap_now = req_valid ? pick_gap(tx_quiet) : tx_idle_left;
                if (gap_now > 0)
                begin
                    req_valid    <= 1'b0;
                    tx_idle_left <= gap_now - 1;
                end
                else if (request_queue.size() != 0 && request_queue[0].hold_idle)
                begin
                    // sender waits here until every result has come back
                    req_valid    <= 1'b0;
                    tx_idle_left <= 0;
                    if (pending_results.size() == 0)
                        request_queue.delete(0);
                end
                else if (request_queue.size() != 0)
                begin
                    nxt = request_queue.pop_front();
                    req_valid    <= 1'b1;
                    req          <= nxt.beat;
                    tx_idle_left <= 0;
                end
                else
                begin
                    req_valid    <= 1'b0;
                    tx_idle_left <= 0;
                end
            end
        end
    end

    // result monitor: checks accepted beats and drives random stalls
    always @(posedge clk or negedge rst_n)
    begin
        brf_pkg::rsp_beat_t want;
        int                 g;
        if (!rst_n)
        begin
            rsp_stall     <= 1'b0;
            rx_stall_left <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result beat with no expectation: %h", rsp);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data: expected %0h, got %0h", want.read_data,
                               rsp.read_data);
                        fail_count++;
                    end
                    if (rsp.error_flag !== want.error_flag)
                    begin
                        $error("error_flag: expected %0b, got %0b", want.error_flag,
                               rsp.error_flag);
                        fail_count++;
                    end
                    if (rsp.byte_count !== want.byte_count)
                    begin
                        $error("byte_count: expected %0d, got %0d", want.byte_count,
                               rsp.byte_count);
                        fail_count++;
                    end
                    if (rsp.parse_request !== want.parse_request)
                    begin
                        $error("parse_request: expected %0b, got %0b",
                               want.parse_request, rsp.parse_request);
                        fail_count++;
                    end
                end
            end
            if (rx_stall_left > 0)
            begin
                rsp_stall     <= 1'b1;
                rx_stall_left <= rx_stall_left - 1;
            end
            else
            begin
                g = pick_gap(rx_quiet);
                rsp_stall     <= (g > 0);
                rx_stall_left <= (g > 0) ? g - 1 : 0;
            end
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        traffic_mix_t mix;
        int           issued;
        int           seg_len;
        int           r;
        int           w_lim;
        int           rd_lim;
        int           pk_lim;

        for (int i = 0; i < RING_DEPTH; i++)
            ring_mem[i] = 8'h00;
        wr_ptr    = '0;
        rd_ptr    = '0;
        ring_fill = RING_EMPTY;

        // directed: empty errors, byte extremes, terminator, peek range
        queue_req(brf_pkg::REQ_READ,  8'hFF, 8'h00);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_PEEK,  8'hFF, 8'hFF);
        queue_req(REQ_UNUSED,         8'hFF, 8'hFF);
        queue_req(brf_pkg::REQ_WRITE, 8'h00, 8'hFF);
        queue_req(brf_pkg::REQ_WRITE, 8'hFF, 8'h00);
        queue_req(brf_pkg::REQ_WRITE, brf_pkg::TERMINATOR, 8'h00);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'h02);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'h03);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'hFF);
        queue_req(REQ_UNUSED,         8'h00, 8'h00);
        queue_req(brf_pkg::REQ_READ,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_READ,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_READ,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_READ,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_PEEK,  8'h00, 8'h00);
        queue_req(brf_pkg::REQ_WRITE, brf_pkg::TERMINATOR, 8'h00);
        queue_req(brf_pkg::REQ_READ,  8'h00, 8'h00);
        queue_hold_idle();

        // fill to full, then write while full, peek the far end and wrap
        for (int i = 0; i < RING_DEPTH; i++)
            queue_req(brf_pkg::REQ_WRITE, rand_data(), rand_offset());
        queue_req(brf_pkg::REQ_WRITE, brf_pkg::TERMINATOR, 8'h00);
        queue_req(brf_pkg::REQ_WRITE, 8'hA5, 8'h00);
        queue_req(brf_pkg::REQ_PEEK, 8'h00, 8'hFF);
        queue_req(brf_pkg::REQ_PEEK, 8'h00, 8'h00);
        queue_req(brf_pkg::REQ_READ, 8'h00, 8'h00);
        queue_req(brf_pkg::REQ_WRITE, rand_data(), 8'h00);
        queue_req(brf_pkg::REQ_WRITE, rand_data(), 8'h00);
        queue_req(brf_pkg::REQ_PEEK, 8'h00, 8'hFF);
        queue_hold_idle();

        // random segments of differing traffic mix, up to the item budget
        issued = request_queue.size();
        while (issued < TOTAL_ITEMS)
        begin
            mix = traffic_mix_t'($urandom_range(0, 3));
            case (mix)
                MIX_FILL:
                begin
                    w_lim = 75; rd_lim = 85; pk_lim = 97;
                end
                MIX_DRAIN:
                begin
                    w_lim = 10; rd_lim = 85; pk_lim = 97;
                end
                MIX_BALANCED:
                begin
                    w_lim = 40; rd_lim = 75; pk_lim = 97;
                end
                default:
                begin
                    w_lim = 25; rd_lim = 45; pk_lim = 97;
                end
            endcase
            seg_len = (mix == MIX_FILL) ? $urandom_range(40, 300) : $urandom_range(10, 120);
            for (int i = 0; i < seg_len && issued < TOTAL_ITEMS; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < w_lim)
                    queue_req(brf_pkg::REQ_WRITE, rand_data(), rand_offset());
                else if (r < rd_lim)
                    queue_req(brf_pkg::REQ_READ, rand_data(), rand_offset());
                else if (r < pk_lim)
                    queue_req(brf_pkg::REQ_PEEK, rand_data(), rand_offset());
                else
                    queue_req(REQ_UNUSED, rand_data(), rand_offset());
                issued++;
            end
            if ($urandom_range(0, 5) == 0)
                queue_hold_idle();
        end

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        while (request_queue.size() != 0 || req_valid)
            @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        if (fail_count == 0 && pending_results.size() == 0)
            $display("byte_ring_fifo_with_terminator_unit test passed");
        else
            $display("byte_ring_fifo_with_terminator_unit test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #15_000_000;
        $display("byte_ring_fifo_with_terminator_unit test failed");
        $finish;
    end

endmodule
